// ===== hdl/e3b_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package e3b_pkg;

	localparam int MAX_ARMS     = 16;
	localparam int ARM_W        = $clog2(MAX_ARMS);
	localparam int K_W          = ARM_W + 1;
	localparam int WEIGHT_BITS  = 32;
	localparam int PROB_W       = 17;
	localparam int GAMMA_W      = 16;
	localparam int SUM_W        = PROB_W + ARM_W;
	localparam int SERIES_TERMS = 13;
	localparam int DIVN_W       = 33;
	localparam int DIVD_W       = SUM_W;
	localparam int DCNT_W       = $clog2(DIVN_W + 1);

	localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = WEIGHT_BITS'(65536);
	localparam logic [PROB_W-1:0]      PROB_ONE   = 17'd65536;
	localparam logic [31:0]            Q30_ONE    = 32'h4000_0000;
	localparam logic [31:0]            X_LIMIT    = 32'd17 << 16;

	localparam logic REQ_CHOOSE = 1'b0;
	localparam logic REQ_REWARD = 1'b1;

	localparam logic CFG_NUM_ARMS    = 1'b0;
	localparam logic CFG_EXPLORATION = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [3:0]  arm_index;
		logic [15:0] reward;
		logic [15:0] random_draw;
	} req_t;

	typedef struct packed {
		logic [3:0]  chosen_arm;
		logic [16:0] chosen_probability;
	} rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RW_DIV,
		ST_MAX,
		ST_SER_MUL,
		ST_SER_DIVST,
		ST_SER_DIV,
		ST_ARM_MUL,
		ST_ARM_DIVST,
		ST_ARM_DIV,
		ST_POW,
		ST_POW_ACC,
		ST_ARM_STORE,
		ST_GK_DIV,
		ST_P_MUL,
		ST_P_DIVST,
		ST_P_DIV,
		ST_TGT_MUL,
		ST_TGT,
		ST_WALK,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

// ===== hdl/exp3_bandit_arm_selector_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Reward request: the weight is written once its divide ends, no response.
// Choose request: the work grows with k, the arms in use (more on the first choose after
// reset, which builds exp(-1)); one shared divider
// runs up to 15 times per arm, and one registered 32x32 multiplier serves all products.
// One request at a time; a new request is taken while a response waits to be taken.
// Reset (arst_n low, asynchronous): all weights 1.0, k = 2, gamma = 6554, idle.
module exp3_bandit_arm_selector_core (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                req_valid,
	output logic               req_ready,
	input  wire e3b_pkg::req_t req,
	output logic               rsp_valid,
	input  wire                rsp_ready,
	output e3b_pkg::rsp_t      rsp,
	input  wire                cfg_we,
	input  wire                cfg_index,
	input  wire [15:0]         cfg_data
);
	import e3b_pkg::*;

	state_t state_q, state_d;

	logic [WEIGHT_BITS-1:0] weight_q [MAX_ARMS];
	logic [PROB_W-1:0]      e_q [MAX_ARMS];
	logic [PROB_W-1:0]      p_q [MAX_ARMS];

	logic [K_W-1:0]         num_arms_q;
	logic [GAMMA_W-1:0]     gamma_q;
	logic [PROB_W-1:0]      last_prob_q;
	logic [WEIGHT_BITS-1:0] last_w_q;
	logic [31:0]            e1_q;
	logic                   e1_valid_q;
	req_t                   req_q;
	logic [K_W-1:0]         idx_q;
	logic [WEIGHT_BITS-1:0] max_q;
	logic [31:0]            term_q, acc_q, ser_r_q;
	logic [3:0]             ser_n_q;
	logic                   ser_e1_q;
	logic [4:0]             pow_q;
	logic [SUM_W-1:0]       esum_q, psum_q, run_q, target_q;
	logic [GAMMA_W-1:0]     gk_q;
	logic [ARM_W-1:0]       pick_q;
	logic [PROB_W-1:0]      pick_p_q;
	logic [WEIGHT_BITS-1:0] pick_w_q;
	rsp_t                   rsp_q;
	logic                   rsp_valid_q;
	logic [63:0]            mul_q;

	logic [DIVN_W-1:0]      div_quo_q;
	logic [DIVD_W-1:0]      div_rem_q, div_den_q;
	logic [DCNT_W-1:0]      div_cnt_q;

	logic [K_W-1:0]         k_eff;
	logic                   last_arm, div_done, accept, out_free, load_rsp;
	logic [WEIGHT_BITS-1:0] w_i;
	logic [PROB_W-1:0]      e_i, p_i;
	logic [31:0]            mul_a, mul_b;
	logic                   div_start;
	logic [DIVN_W-1:0]      div_num;
	logic [DIVD_W-1:0]      div_den;
	logic signed [33:0]     ser_sum;
	logic [31:0]            acc_clamped, x_val;
	logic [32:0]            round_sum, rw_sum;
	logic [PROB_W-1:0]      e_round, p_new;
	logic [SUM_W-1:0]       run_next;
	logic [WEIGHT_BITS-1:0] est, upd_weight;
	logic [DIVD_W:0]        div_shift, div_diff;
	logic                   div_ge;

	// Clamp the arm count into its usable range
	always_comb begin
		if (num_arms_q == '0) begin
			k_eff = K_W'(1);
		end else if (num_arms_q > K_W'(MAX_ARMS)) begin
			k_eff = K_W'(MAX_ARMS);
		end else begin
			k_eff = num_arms_q;
		end
	end

	assign last_arm = (idx_q == k_eff - K_W'(1));
	assign w_i      = weight_q[idx_q[ARM_W-1:0]];
	assign e_i      = e_q[idx_q[ARM_W-1:0]];
	assign p_i      = p_q[idx_q[ARM_W-1:0]];
	assign div_done = (div_cnt_q == '0);
	assign accept   = req_valid && req_ready;
	assign out_free = !rsp_valid_q || rsp_ready;
	assign load_rsp = (state_q == ST_DONE) && out_free;

	// Series step: add or subtract the new term, floor at zero
	always_comb begin
		if (ser_n_q[0]) begin
			ser_sum = $signed({2'b00, acc_q}) - $signed({2'b00, div_quo_q[31:0]});
		end else begin
			ser_sum = $signed({2'b00, acc_q}) + $signed({2'b00, div_quo_q[31:0]});
		end
		acc_clamped = ser_sum[33] ? 32'd0 : ser_sum[31:0];
	end

	assign x_val      = div_quo_q[31:0];
	assign round_sum  = {1'b0, acc_q} + 33'd8192;
	assign e_round    = round_sum[30:14];
	assign p_new      = div_quo_q[PROB_W-1:0] + {1'b0, gk_q};
	assign run_next   = run_q + SUM_W'(p_i);
	assign est        = (last_prob_q == '0) ? '1 : div_quo_q[31:0];
	assign rw_sum     = {1'b0, last_w_q} + {1'b0, est};
	assign upd_weight = rw_sum[32] ? '1 : rw_sum[31:0];

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (req.req_type == REQ_REWARD) ? ST_RW_DIV : ST_MAX;
				end
			end
			ST_RW_DIV: if (div_done) state_d = ST_IDLE;
			ST_MAX: begin
				if (last_arm) begin
					state_d = e1_valid_q ? ST_ARM_MUL : ST_SER_MUL;
				end
			end
			ST_SER_MUL:   state_d = ST_SER_DIVST;
			ST_SER_DIVST: state_d = ST_SER_DIV;
			ST_SER_DIV: begin
				if (div_done) begin
					if (ser_n_q == 4'(SERIES_TERMS)) begin
						state_d = ser_e1_q ? ST_ARM_MUL : ST_POW;
					end else begin
						state_d = ST_SER_MUL;
					end
				end
			end
			ST_ARM_MUL:   state_d = ST_ARM_DIVST;
			ST_ARM_DIVST: state_d = ST_ARM_DIV;
			ST_ARM_DIV: begin
				if (div_done) begin
					state_d = (x_val >= X_LIMIT) ? ST_POW : ST_SER_MUL;
				end
			end
			ST_POW:       state_d = (pow_q == '0) ? ST_ARM_STORE : ST_POW_ACC;
			ST_POW_ACC:   state_d = ST_POW;
			ST_ARM_STORE: state_d = last_arm ? ST_GK_DIV : ST_ARM_MUL;
			ST_GK_DIV:    if (div_done) state_d = ST_P_MUL;
			ST_P_MUL:     state_d = ST_P_DIVST;
			ST_P_DIVST:   state_d = ST_P_DIV;
			ST_P_DIV: begin
				if (div_done) state_d = last_arm ? ST_TGT_MUL : ST_P_MUL;
			end
			ST_TGT_MUL:   state_d = ST_TGT;
			ST_TGT:       state_d = ST_WALK;
			ST_WALK: begin
				if (run_next > target_q || last_arm) state_d = ST_DONE;
			end
			ST_DONE:      if (out_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// Operand select for the shared multiplier and divider
	always_comb begin
		req_ready = (state_q == ST_IDLE);
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid && req.req_type == REQ_REWARD) begin
					div_start = 1'b1;
					div_num   = {1'b0, req.reward, 16'd0};
					div_den   = DIVD_W'(last_prob_q);
				end
			end
			ST_SER_MUL: begin
				mul_a = term_q;
				mul_b = ser_r_q;
			end
			ST_SER_DIVST: begin
				div_start = 1'b1;
				div_num   = mul_q[62:30];
				div_den   = DIVD_W'(ser_n_q);
			end
			ST_ARM_MUL: begin
				mul_a = 32'(gamma_q);
				mul_b = max_q - w_i;
			end
			ST_ARM_DIVST: begin
				div_start = 1'b1;
				div_num   = {1'b0, mul_q[47:16]};
				div_den   = DIVD_W'(k_eff);
			end
			ST_POW: begin
				mul_a = acc_q;
				mul_b = e1_q;
			end
			ST_ARM_STORE: begin
				if (last_arm) begin
					div_start = 1'b1;
					div_num   = DIVN_W'(gamma_q);
					div_den   = DIVD_W'(k_eff);
				end
			end
			ST_P_MUL: begin
				mul_a = 32'(PROB_ONE - PROB_W'(gamma_q));
				mul_b = 32'(e_i);
			end
			ST_P_DIVST: begin
				div_start = 1'b1;
				div_num   = mul_q[DIVN_W-1:0];
				div_den   = esum_q;
			end
			ST_TGT_MUL: begin
				mul_a = 32'(req_q.random_draw);
				mul_b = 32'(psum_q);
			end
			default: begin
			end
		endcase
	end

	// Shared multiplier, product registered
	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	// Shared restoring divider, one quotient bit per cycle
	assign div_shift = {div_rem_q, div_quo_q[DIVN_W-1]};
	assign div_ge    = div_shift >= {1'b0, div_den_q};
	assign div_diff  = div_shift - {1'b0, div_den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (div_start) begin
			div_cnt_q <= DCNT_W'(DIVN_W);
		end else if (!div_done) begin
			div_cnt_q <= div_cnt_q - DCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			div_quo_q <= div_num;
			div_rem_q <= '0;
			div_den_q <= div_den;
		end else if (!div_done) begin
			div_rem_q <= div_ge ? div_diff[DIVD_W-1:0] : div_shift[DIVD_W-1:0];
			div_quo_q <= {div_quo_q[DIVN_W-2:0], div_ge};
		end
	end

	// Control state, configuration, weights and remembered choice
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			num_arms_q  <= K_W'(2);
			gamma_q     <= 16'd6554;
			last_prob_q <= PROB_ONE;
			last_w_q    <= WEIGHT_ONE;
			e1_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
			for (int j = 0; j < MAX_ARMS; j++) begin
				weight_q[j] <= WEIGHT_ONE;
			end
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == CFG_NUM_ARMS) begin
					num_arms_q <= cfg_data[K_W-1:0];
				end else begin
					gamma_q <= cfg_data;
				end
			end
			if (state_q == ST_RW_DIV && div_done) begin
				weight_q[req_q.arm_index] <= upd_weight;
			end
			if (state_q == ST_SER_DIV && div_done && ser_e1_q &&
					ser_n_q == 4'(SERIES_TERMS)) begin
				e1_valid_q <= 1'b1;
			end
			if (load_rsp) begin
				last_prob_q <= pick_p_q;
				last_w_q    <= pick_w_q;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers advanced by the sequencer
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					req_q <= req;
					idx_q <= '0;
					max_q <= '0;
				end
			end
			ST_MAX: begin
				if (w_i > max_q) max_q <= w_i;
				esum_q <= '0;
				if (last_arm) begin
					idx_q    <= '0;
					term_q   <= Q30_ONE;
					acc_q    <= Q30_ONE;
					ser_r_q  <= Q30_ONE;
					ser_n_q  <= 4'd1;
					ser_e1_q <= 1'b1;
				end else begin
					idx_q <= idx_q + K_W'(1);
				end
			end
			ST_SER_DIV: begin
				if (div_done) begin
					term_q <= div_quo_q[31:0];
					acc_q  <= acc_clamped;
					if (ser_n_q == 4'(SERIES_TERMS)) begin
						if (ser_e1_q) e1_q <= acc_clamped;
						ser_e1_q <= 1'b0;
					end else begin
						ser_n_q <= ser_n_q + 4'd1;
					end
				end
			end
			ST_ARM_DIV: begin
				if (div_done) begin
					if (x_val >= X_LIMIT) begin
						acc_q <= '0;
						pow_q <= '0;
					end else begin
						pow_q    <= x_val[20:16];
						ser_r_q  <= {2'b00, x_val[15:0], 14'd0};
						term_q   <= Q30_ONE;
						acc_q    <= Q30_ONE;
						ser_n_q  <= 4'd1;
						ser_e1_q <= 1'b0;
					end
				end
			end
			ST_POW_ACC: begin
				acc_q <= mul_q[61:30];
				pow_q <= pow_q - 5'd1;
			end
			ST_ARM_STORE: begin
				e_q[idx_q[ARM_W-1:0]] <= e_round;
				esum_q <= esum_q + SUM_W'(e_round);
				idx_q  <= last_arm ? '0 : idx_q + K_W'(1);
			end
			ST_GK_DIV: begin
				if (div_done) begin
					gk_q   <= div_quo_q[GAMMA_W-1:0];
					psum_q <= '0;
					if (esum_q == '0) esum_q <= SUM_W'(1);
				end
			end
			ST_P_DIV: begin
				if (div_done) begin
					p_q[idx_q[ARM_W-1:0]] <= p_new;
					psum_q <= psum_q + SUM_W'(p_new);
					idx_q  <= last_arm ? '0 : idx_q + K_W'(1);
				end
			end
			ST_TGT: begin
				target_q <= mul_q[SUM_W+15:16];
				run_q    <= '0;
			end
			ST_WALK: begin
				run_q    <= run_next;
				pick_q   <= idx_q[ARM_W-1:0];
				pick_p_q <= p_i;
				pick_w_q <= w_i;
				idx_q    <= idx_q + K_W'(1);
			end
			ST_DONE: begin
				if (out_free) begin
					rsp_q.chosen_arm         <= pick_q;
					rsp_q.chosen_probability <= pick_p_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

// ===== hdl/e3b_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module e3b_checker (
	input wire                clk,
	input wire                arst_n,
	input wire                req_valid,
	input wire                req_ready,
	input wire e3b_pkg::req_t req,
	input wire                rsp_valid,
	input wire                rsp_ready,
	input wire e3b_pkg::rsp_t rsp
);
	import e3b_pkg::*;

	// A stalled response stays up
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	// A stalled response keeps its payload
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp))
		else $error("response payload changed while stalled");

	// One request at a time: busy right after taking one
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while still busy");

	// A probability never exceeds one
	a_prob_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.chosen_probability <= PROB_ONE)
		else $error("probability above one");

	// A reward never produces a response on the next cycle
	a_reward_silent: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.req_type == REQ_REWARD && !rsp_valid |=> !rsp_valid)
		else $error("response after reward request");

endmodule

bind exp3_bandit_arm_selector_core e3b_checker u_e3b_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
`default_nettype wire

// ===== sim/tb_exp3_bandit_arm_selector_core.sv =====
`timescale 1ns / 1ps
module tb_exp3_bandit_arm_selector_core;
	import e3b_pkg::*;

	localparam longint unsigned WMAX      = 64'hFFFF_FFFF;
	localparam longint unsigned DIFF_CAP  = (64'd1 << 47) - 1;
	localparam longint unsigned Q30       = 64'd1 << 30;
	localparam int              DRAIN_CYC = 60;

	// Bandit policy model and queue of pending choose responses
	class bandit_scoreboard;
		longint unsigned weight[MAX_ARMS];
		longint unsigned last_prob;
		longint unsigned last_wt;
		int unsigned     arms_cfg;
		longint unsigned gamma;
		longint unsigned exp_m1;
		rsp_t            pending[$];
		int              errors;

		function new();
			foreach (weight[i])
				weight[i] = 65536;
			last_prob = 65536;
			last_wt   = 65536;
			arms_cfg  = 2;
			gamma     = 6554;
			errors    = 0;
			exp_m1    = exp_series(Q30);
		endfunction

		// Taylor series of exp(-r), Q2.30, partial sums clamped at zero
		function longint unsigned exp_series(longint unsigned r);
			longint          acc;
			longint unsigned term;
			acc  = Q30;
			term = Q30;
			for (int n = 1; n <= SERIES_TERMS; n++) begin
				term = ((term * r) >> 30) / n;
				if (n % 2)
					acc -= longint'(term);
				else
					acc += longint'(term);
				if (acc < 0)
					acc = 0;
			end
			return longint'(acc);
		endfunction

		function longint unsigned neg_exp(longint unsigned x);
			longint unsigned val;
			if (x >= (64'd17 << 16))
				return 0;
			val = exp_series((x & 64'hFFFF) << 14);
			for (longint unsigned i = 0; i < (x >> 16); i++)
				val = (val * exp_m1) >> 30;
			return (val + (64'd1 << 13)) >> 14;
		endfunction

		function void write_reg(logic idx, logic [15:0] val);
			if (idx == CFG_NUM_ARMS)
				arms_cfg = val[4:0];
			else
				gamma = val;
		endfunction

		// Apply an accepted request; queue a response for choose
		function void note_request(req_t r);
			int unsigned     k;
			longint unsigned m, d, esum, psum, target, run, est;
			longint unsigned e[MAX_ARMS];
			longint unsigned p[MAX_ARMS];
			int unsigned     pick;
			rsp_t            rs;
			k = arms_cfg;
			if (k < 1)
				k = 1;
			if (k > MAX_ARMS)
				k = MAX_ARMS;
			if (r.req_type == REQ_REWARD) begin
				if (last_prob == 0)
					est = WMAX;
				else
					est = (longint'(r.reward) << 16) / last_prob;
				if (est > WMAX || last_wt > WMAX - est)
					weight[r.arm_index] = WMAX;
				else
					weight[r.arm_index] = last_wt + est;
				return;
			end
			m = 0;
			for (int i = 0; i < k; i++)
				if (weight[i] > m)
					m = weight[i];
			esum = 0;
			for (int i = 0; i < k; i++) begin
				d = m - weight[i];
				if (d > DIFF_CAP)
					d = DIFF_CAP;
				e[i] = neg_exp((gamma * d) / (longint'(k) << 16));
				esum += e[i];
			end
			if (esum == 0)
				esum = 1;
			psum = 0;
			for (int i = 0; i < k; i++) begin
				p[i] = ((65536 - gamma) * e[i]) / esum + gamma / k;
				psum += p[i];
			end
			target = (longint'(r.random_draw) * psum) >> 16;
			pick   = k - 1;
			run    = 0;
			for (int i = 0; i < k; i++) begin
				run += p[i];
				if (run > target) begin
					pick = i;
					break;
				end
			end
			last_prob = p[pick];
			last_wt   = weight[pick];
			rs.chosen_arm         = pick[3:0];
			rs.chosen_probability = p[pick][16:0];
			pending.push_back(rs);
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (pending.size() == 0) begin
				$error("unexpected response arm=%0d prob=%0d",
					got.chosen_arm, got.chosen_probability);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.chosen_arm !== want.chosen_arm) begin
				$error("chosen_arm expected %0d actual %0d", want.chosen_arm, got.chosen_arm);
				errors++;
			end
			if (got.chosen_probability !== want.chosen_probability) begin
				$error("chosen_probability expected %0d actual %0d",
					want.chosen_probability, got.chosen_probability);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	req_t        req = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	rsp_t        rsp;
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_NUM_ARMS;
	logic [15:0] cfg_data = '0;

	bandit_scoreboard sb = new();
	int unsigned      requests_sent = 0;
	int unsigned      responses_seen = 0;

	exp3_bandit_arm_selector_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// Abort a hung run
	initial begin
		#100ms;
		$display("** exp3_bandit_arm_selector_core: FAILED **");
		$finish;
	end

	function automatic int unsigned pick_gap();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(20, 80);
		if ($urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 3);
	endfunction

	// Offer one request and hold it until accepted
	task automatic send_request(req_t r, int unsigned gap);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do
			@(posedge clk);
		while (!req_ready);
		sb.note_request(r);
		requests_sent++;
	endtask

	// Drain outstanding work, then write one register
	task automatic write_reg(logic idx, logic [15:0] val);
		req_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, val);
	endtask

	function automatic req_t make_choose(logic [15:0] draw);
		req_t r;
		r.req_type    = REQ_CHOOSE;
		r.arm_index   = 4'($urandom);
		r.reward      = 16'($urandom);
		r.random_draw = draw;
		return r;
	endfunction

	function automatic req_t make_reward(logic [3:0] arm, logic [15:0] rw);
		req_t r;
		r.req_type    = REQ_REWARD;
		r.arm_index   = arm;
		r.reward      = rw;
		r.random_draw = 16'($urandom);
		return r;
	endfunction

	// Response side: random backpressure plus one long hold-off from the first request
	initial begin
		bit          held;
		int unsigned stall;
		held  = 1'b0;
		stall = 0;
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready) begin
				sb.check_result(rsp);
				responses_seen++;
			end
			if (!held && requests_sent != 0 && responses_seen == 0) begin
				held  = 1'b1;
				stall = 6000;
			end else if (stall == 0 && $urandom_range(0, 3) == 0) begin
				stall = pick_gap();
			end
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				stall--;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// Stimulus
	initial begin
		int unsigned k_eff;
		int unsigned n_items;
		int unsigned sel;
		logic [4:0]  k_val;
		req_t        r;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset settings, draw and reward extremes
		send_request(make_choose(16'h0000), 0);
		send_request(make_reward(4'd0, 16'hFFFF), 0);
		send_request(make_choose(16'hFFFF), 1);
		send_request(make_reward(4'd1, 16'h0000), 0);
		send_request(make_choose(16'h8000), 0);
		// index beyond arms in use, used once k grows
		send_request(make_reward(4'd15, 16'hFFFF), 0);
		// zero arm count acts as one, gamma at both ends
		write_reg(CFG_NUM_ARMS, 16'd0);
		write_reg(CFG_EXPLORATION, 16'd0);
		send_request(make_choose(16'hFFFF), 0);
		send_request(make_reward(4'd0, 16'hFFFF), 0);
		send_request(make_choose(16'h1234), 0);
		write_reg(CFG_EXPLORATION, 16'hFFFF);
		send_request(make_choose(16'hFFFF), 0);
		// arm count above the store acts as the maximum
		write_reg(CFG_NUM_ARMS, 16'd31);
		write_reg(CFG_EXPLORATION, 16'd0);
		send_request(make_choose(16'hFFFF), 0);
		send_request(make_reward(4'd3, 16'hFFFF), 0);
		send_request(make_choose(16'h0001), 0);
		write_reg(CFG_NUM_ARMS, 16'd16);
		write_reg(CFG_EXPLORATION, 16'd40000);
		send_request(make_choose(16'hFFFE), 0);
		send_request(make_reward(4'd15, 16'h7FFF), 0);
		send_request(make_choose(16'h0000), 0);

		// Random phases: mostly small arm counts, mixed choose and reward requests, rewards mostly within the arms in use
		while (requests_sent < 750) begin
			sel = $urandom_range(0, 9);
			if (sel <= 6)
				k_val = 5'($urandom_range(1, 4));
			else if (sel == 7)
				k_val = 5'd0;
			else if (sel == 8)
				k_val = 5'($urandom_range(5, 15));
			else
				k_val = 5'($urandom_range(16, 31));
			write_reg(CFG_NUM_ARMS, {11'd0, k_val});
			sel = $urandom_range(0, 5);
			write_reg(CFG_EXPLORATION, sel == 0 ? 16'd0 : sel == 1 ? 16'hFFFF :
				16'($urandom));
			k_eff   = k_val == 0 ? 1 : k_val > MAX_ARMS ? MAX_ARMS : k_val;
			n_items = k_eff > 4 ? 6 : 36;
			for (int i = 0; i < n_items; i++) begin
				sel = $urandom_range(0, 9);
				if (sel < 5)
					r = make_choose(16'($urandom));
				else if (sel < 9)
					r = make_reward(4'($urandom_range(0, k_eff - 1)), 16'($urandom));
				else
					r = make_reward(4'($urandom), 16'($urandom));
				send_request(r, pick_gap());
			end
		end

		req_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		if (sb.errors == 0)
			$display("** exp3_bandit_arm_selector_core: PASSED **");
		else
			$display("** exp3_bandit_arm_selector_core: FAILED **");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/e3b_pkg.sv
hdl/exp3_bandit_arm_selector_core.sv
hdl/e3b_checker.sv
sim/tb_exp3_bandit_arm_selector_core.sv
